// File: src/open_address_hash_table_core_macros.svh
// assertion macros for the hash table core checker
`ifndef OPEN_ADDRESS_HASH_TABLE_CORE_MACROS_SVH
`define OPEN_ADDRESS_HASH_TABLE_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define OAHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define OAHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/oaht_pkg.sv
package oaht_pkg;

  // default sizes
  localparam int unsigned SLOTS_DEF       = 1024;
  localparam int unsigned KEY_WIDTH_DEF   = 32;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // fixed field widths
  localparam int unsigned OP_W          = 2;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned MARK_W        = 2;
  localparam int unsigned CFG_W         = 4;
  localparam int unsigned ENTRY_COUNT_W = 10;
  localparam int unsigned LG_W          = 5;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [MARK_W-1:0]   mark_t;
  typedef logic [CFG_W-1:0]    cfg_t;
  typedef logic [LG_W-1:0]     lg_t;

  // hash and load limit
  localparam logic [31:0] HASH_MULT  = 32'h0100_0193;
  localparam int unsigned LOAD_NUM   = 3;
  localparam int unsigned LOAD_SHIFT = 2;

  // capacity register range
  localparam cfg_t CAP_LOG2_MIN   = 4'd3;
  localparam cfg_t CAP_LOG2_MAX   = 4'd10;
  localparam cfg_t CAP_LOG2_RESET = 4'd3;

  // operation codes
  localparam op_t OP_GET    = 2'd0;
  localparam op_t OP_INSERT = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;

  // status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_EXISTS    = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  // slot marks
  localparam mark_t MARK_EMPTY    = 2'd0;
  localparam mark_t MARK_OCCUPIED = 2'd1;
  localparam mark_t MARK_DELETED  = 2'd2;

endpackage

// File: src/open_address_hash_table_core.sv
// channel | handshake           | payload
// --------+---------------------+------------------------------------------
// in      | in_valid / in_stall | in_op, in_key, in_value
// out     | out_valid/out_stall | out_status, out_value_out, out_entry_count
// cfg     | cfg_wr_en           | cfg_wr_data (capacity_log2)
//
// one transaction at a time: accept and hash, then one read of the slot memory
// per probed slot, then post the result
// a full insert or an unknown op skips the probe and goes straight to the result
// reset and every cfg write start a clearing pass over all SLOTS slots of the
// slot memory, in_stall stays high meanwhile
// a finished result sits in the output register; a new transaction may be
// accepted while out_stall holds it
module open_address_hash_table_core #(
  parameter int unsigned SLOTS       = oaht_pkg::SLOTS_DEF,
  parameter int unsigned KEY_WIDTH   = oaht_pkg::KEY_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH = oaht_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_wr_en,
  input  oaht_pkg::cfg_t                        cfg_wr_data,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  oaht_pkg::op_t                         in_op,
  input  logic signed [KEY_WIDTH-1:0]           in_key,
  input  logic [VALUE_WIDTH-1:0]                in_value,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output oaht_pkg::status_t                     out_status,
  output logic [VALUE_WIDTH-1:0]                out_value_out,
  output logic [oaht_pkg::ENTRY_COUNT_W-1:0]    out_entry_count
);

  // slot index width, counter width, largest usable log2 capacity
  localparam int unsigned IDX_W    = $clog2(SLOTS);
  localparam int unsigned CNT_W    = $clog2(SLOTS + 1);
  localparam int unsigned LG_FLOOR = $clog2(SLOTS + 1) - 1;
  localparam logic [IDX_W-1:0] MULT_LO = oaht_pkg::HASH_MULT[IDX_W-1:0];
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

  // sequencer states
  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_PROBE  = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  // one slot of the table: mark, key and payload share a memory word
  typedef struct packed {
    oaht_pkg::mark_t        mark;
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] payload;
  } slot_t;

  slot_t slot_mem [SLOTS];
  slot_t rd_q;

  // control state
  logic [1:0]          state_r,     state_nxt;
  oaht_pkg::cfg_t      cap_lg_r,    cap_lg_nxt;
  logic [CNT_W-1:0]    occ_r,       occ_nxt;
  logic [CNT_W-1:0]    tomb_cnt_r,  tomb_cnt_nxt;
  logic [IDX_W-1:0]    clr_idx_r,   clr_idx_nxt;
  logic                have_tomb_r, have_tomb_nxt;
  logic                out_valid_r, out_valid_nxt;

  // transaction payload
  oaht_pkg::op_t          op_r,        op_nxt;
  logic [KEY_WIDTH-1:0]   key_r,       key_nxt;
  logic [VALUE_WIDTH-1:0] value_r,     value_nxt;
  logic [IDX_W-1:0]       idx_r,       idx_nxt;
  logic [IDX_W-1:0]       probe_cnt_r, probe_cnt_nxt;
  logic [IDX_W-1:0]       tomb_idx_r,  tomb_idx_nxt;
  oaht_pkg::status_t      res_status_r, res_status_nxt;
  logic [VALUE_WIDTH-1:0] res_value_r,  res_value_nxt;

  // output register
  oaht_pkg::status_t                  out_status_r,  out_status_nxt;
  logic [VALUE_WIDTH-1:0]             out_value_r,   out_value_nxt;
  logic [oaht_pkg::ENTRY_COUNT_W-1:0] out_count_r,   out_count_nxt;

  // memory write port
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_t            wr_data;

  // capacity in use
  oaht_pkg::cfg_t        lg_clamp;
  oaht_pkg::lg_t         lg_eff;
  logic [CNT_W-1:0]      cap;
  logic [IDX_W-1:0]      cap_mask;
  logic [CNT_W+1:0]      load_limit;
  logic [CNT_W+1:0]      load_used;
  logic                  table_full;

  // hash of the incoming key
  logic [63:0]           key_ext;
  logic [IDX_W-1:0]      key_lo;
  logic [IDX_W-1:0]      hash_lo;

  // probe decode
  logic                  slot_hit;
  logic                  probe_last;
  logic                  tomb_seen;
  logic [IDX_W-1:0]      tomb_at;
  logic                  in_take;
  logic                  out_free;

  // clamp the register to 3..10, then to what SLOTS holds
  always_comb begin
    if (cap_lg_r < oaht_pkg::CAP_LOG2_MIN) begin
      lg_clamp = oaht_pkg::CAP_LOG2_MIN;
    end else if (cap_lg_r > oaht_pkg::CAP_LOG2_MAX) begin
      lg_clamp = oaht_pkg::CAP_LOG2_MAX;
    end else begin
      lg_clamp = cap_lg_r;
    end
    if (oaht_pkg::LG_W'(lg_clamp) > oaht_pkg::LG_W'(LG_FLOOR)) begin
      lg_eff = oaht_pkg::LG_W'(LG_FLOOR);
    end else begin
      lg_eff = oaht_pkg::LG_W'(lg_clamp);
    end
  end

  assign cap        = CNT_W'(1) << lg_eff;
  assign cap_mask   = IDX_W'(cap - CNT_W'(1));
  // three quarters of the capacity: cap * 3 / 4
  assign load_limit = ((CNT_W + 2)'(cap) * (CNT_W + 2)'(oaht_pkg::LOAD_NUM))
                      >> oaht_pkg::LOAD_SHIFT;
  assign load_used  = (CNT_W + 2)'(occ_r) + (CNT_W + 2)'(tomb_cnt_r);
  assign table_full = load_used >= load_limit;

  // only the low index bits of the 32-bit product reach the slot index, and
  // those depend on the low bits of key and multiplier alone
  assign key_ext = 64'($unsigned(in_key));
  assign key_lo  = key_ext[IDX_W-1:0];
  assign hash_lo = key_lo * MULT_LO;

  // rd_q always holds the slot at idx_r while probing
  assign slot_hit   = (rd_q.mark == oaht_pkg::MARK_OCCUPIED) && (rd_q.key == key_r);
  assign probe_last = probe_cnt_r == cap_mask;
  assign tomb_seen  = have_tomb_r || (rd_q.mark == oaht_pkg::MARK_DELETED);
  assign tomb_at    = have_tomb_r ? tomb_idx_r : idx_r;

  assign in_stall = state_r != S_IDLE;
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cap_lg_nxt     = cap_lg_r;
    occ_nxt        = occ_r;
    tomb_cnt_nxt   = tomb_cnt_r;
    clr_idx_nxt    = clr_idx_r;
    have_tomb_nxt  = have_tomb_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    value_nxt      = value_r;
    idx_nxt        = idx_r;
    probe_cnt_nxt  = probe_cnt_r;
    tomb_idx_nxt   = tomb_idx_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = '{mark: oaht_pkg::MARK_OCCUPIED, key: key_r, payload: value_r};

    case (state_r)
      S_CLEAR: begin
        // sweep every slot back to empty
        wr_en        = 1'b1;
        wr_addr      = clr_idx_r;
        wr_data      = '{mark: oaht_pkg::MARK_EMPTY, key: '0, payload: '0};
        clr_idx_nxt  = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_take) begin
          op_nxt        = in_op;
          key_nxt       = in_key;
          value_nxt     = in_value;
          idx_nxt       = hash_lo & cap_mask;
          probe_cnt_nxt = '0;
          have_tomb_nxt = 1'b0;
          res_value_nxt = '0;
          if (!(in_op inside {oaht_pkg::OP_GET, oaht_pkg::OP_INSERT,
                              oaht_pkg::OP_REMOVE})) begin
            res_status_nxt = oaht_pkg::ST_NOT_FOUND;
            state_nxt      = S_RESULT;
          end else if ((in_op == oaht_pkg::OP_INSERT) && table_full) begin
            // full check comes before the key search
            res_status_nxt = oaht_pkg::ST_FULL;
            state_nxt      = S_RESULT;
          end else begin
            state_nxt = S_PROBE;
          end
        end
      end

      S_PROBE: begin
        if (op_r == oaht_pkg::OP_INSERT) begin
          if (rd_q.mark == oaht_pkg::MARK_EMPTY) begin
            // end of chain: reuse the first tombstone, else this slot
            wr_en          = 1'b1;
            wr_addr        = have_tomb_r ? tomb_idx_r : idx_r;
            occ_nxt        = occ_r + CNT_W'(1);
            if (have_tomb_r) begin
              tomb_cnt_nxt = tomb_cnt_r - CNT_W'(1);
            end
            res_status_nxt = oaht_pkg::ST_OK;
            state_nxt      = S_RESULT;
          end else if (slot_hit) begin
            res_status_nxt = oaht_pkg::ST_EXISTS;
            state_nxt      = S_RESULT;
          end else if (probe_last) begin
            // whole table walked without an empty slot
            if (tomb_seen) begin
              wr_en          = 1'b1;
              wr_addr        = tomb_at;
              occ_nxt        = occ_r + CNT_W'(1);
              tomb_cnt_nxt   = tomb_cnt_r - CNT_W'(1);
              res_status_nxt = oaht_pkg::ST_OK;
            end else begin
              res_status_nxt = oaht_pkg::ST_FULL;
            end
            state_nxt = S_RESULT;
          end else begin
            if ((rd_q.mark == oaht_pkg::MARK_DELETED) && !have_tomb_r) begin
              have_tomb_nxt = 1'b1;
              tomb_idx_nxt  = idx_r;
            end
            idx_nxt       = (idx_r + IDX_W'(1)) & cap_mask;
            probe_cnt_nxt = probe_cnt_r + IDX_W'(1);
          end
        end else begin
          // get and remove share the search
          if (rd_q.mark == oaht_pkg::MARK_EMPTY) begin
            res_status_nxt = oaht_pkg::ST_NOT_FOUND;
            state_nxt      = S_RESULT;
          end else if (slot_hit) begin
            res_status_nxt = oaht_pkg::ST_OK;
            if (op_r == oaht_pkg::OP_GET) begin
              res_value_nxt = rd_q.payload;
            end else begin
              // leave a tombstone behind
              wr_en        = 1'b1;
              wr_addr      = idx_r;
              wr_data      = '{mark: oaht_pkg::MARK_DELETED, key: rd_q.key, payload: '0};
              occ_nxt      = occ_r - CNT_W'(1);
              tomb_cnt_nxt = tomb_cnt_r + CNT_W'(1);
            end
            state_nxt = S_RESULT;
          end else if (probe_last) begin
            res_status_nxt = oaht_pkg::ST_NOT_FOUND;
            state_nxt      = S_RESULT;
          end else begin
            idx_nxt       = (idx_r + IDX_W'(1)) & cap_mask;
            probe_cnt_nxt = probe_cnt_r + IDX_W'(1);
          end
        end
      end

      S_RESULT: begin
        // hand over once the output register is free
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_count_nxt  = oaht_pkg::ENTRY_COUNT_W'(occ_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // capacity write clears the table; write it only while idle, the block does not enforce it
    if (cfg_wr_en) begin
      cap_lg_nxt   = cfg_wr_data;
      occ_nxt      = '0;
      tomb_cnt_nxt = '0;
      clr_idx_nxt  = '0;
      state_nxt    = S_CLEAR;
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    rd_q <= slot_mem[idx_nxt];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cap_lg_r    <= oaht_pkg::CAP_LOG2_RESET;
      occ_r       <= '0;
      tomb_cnt_r  <= '0;
      clr_idx_r   <= '0;
      have_tomb_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_lg_r    <= cap_lg_nxt;
      occ_r       <= occ_nxt;
      tomb_cnt_r  <= tomb_cnt_nxt;
      clr_idx_r   <= clr_idx_nxt;
      have_tomb_r <= have_tomb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    value_r      <= value_nxt;
    idx_r        <= idx_nxt;
    probe_cnt_r  <= probe_cnt_nxt;
    tomb_idx_r   <= tomb_idx_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_value_out   = out_value_r;
  assign out_entry_count = out_count_r;

endmodule

// File: src/oaht_checker.sv
`include "open_address_hash_table_core_macros.svh"

module oaht_checker #(
  parameter int unsigned KEY_WIDTH   = oaht_pkg::KEY_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH = oaht_pkg::VALUE_WIDTH_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               cfg_wr_en,
  input logic                               in_valid,
  input logic                               in_stall,
  input oaht_pkg::op_t                      in_op,
  input logic signed [KEY_WIDTH-1:0]        in_key,
  input logic [VALUE_WIDTH-1:0]             in_value,
  input logic                               out_valid,
  input logic                               out_stall,
  input oaht_pkg::status_t                  out_status,
  input logic [VALUE_WIDTH-1:0]             out_value_out,
  input logic [oaht_pkg::ENTRY_COUNT_W-1:0] out_entry_count
);

  // a waiting input transaction keeps its content
  `OAHT_ASSERT_NEXT(a_in_hold, in_valid && in_stall,
    in_valid && $stable(in_op) && $stable(in_key) && $stable(in_value),
    "input changed while stalled")

  // a held result keeps its content
  `OAHT_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_status) && $stable(out_value_out)
    && $stable(out_entry_count), "result changed while stalled")

  // only a successful transaction carries a value
  `OAHT_ASSERT_NOW(a_value_zero, out_valid && (out_status != oaht_pkg::ST_OK),
    out_value_out == '0, "value on a failed transaction")

  // one transaction at a time
  `OAHT_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall,
    "accepted back to back")

  // a capacity write starts a clearing pass
  `OAHT_ASSERT_NEXT(a_cfg_clears, cfg_wr_en, in_stall,
    "input open right after capacity write")

endmodule

bind open_address_hash_table_core oaht_checker #(
  .KEY_WIDTH   (KEY_WIDTH),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_oaht_checker (.*);

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // table size as built, and the unused fourth operation code
  localparam int unsigned SLOT_COUNT = oaht_pkg::SLOTS_DEF;
  localparam oaht_pkg::op_t OP_UNUSED = 2'd3;

  // watchdog, far above the slowest legal run (clearing passes, stalls, probes)
  localparam int unsigned CYCLE_LIMIT = 400000;

  // one result transaction
  typedef struct packed {
    oaht_pkg::status_t status;
    logic [31:0] value_out;
    logic [oaht_pkg::ENTRY_COUNT_W-1:0] entry_count;
  } result_t;

  // one directed row: the transaction and, where typed, the answer it must get
  typedef struct packed {
    oaht_pkg::op_t op;
    logic [31:0] key;
    logic [31:0] value;
    bit typed;
    result_t want;
  } dir_row_t;

  localparam result_t PREDICTED = '0;

  // capacity 8 after reset: keys that are multiples of 8 share home slot 0,
  // 32'h7fffffff and 32'hffffffff share home slot 5
  localparam int unsigned DIR_ROW_N = 24;
  localparam dir_row_t DIR_ROWS [DIR_ROW_N] = '{
    // empty table after reset
    '{oaht_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{oaht_pkg::ST_NOT_FOUND, 32'h0, 10'd0}},
    '{oaht_pkg::OP_REMOVE, 32'h7fff_ffff, 32'h0000_0000, 1'b1,
      '{oaht_pkg::ST_NOT_FOUND, 32'h0, 10'd0}},
    // unused op code answers not found
    '{OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 1'b1,
      '{oaht_pkg::ST_NOT_FOUND, 32'h0, 10'd0}},
    // most negative key with all-ones payload
    '{oaht_pkg::OP_INSERT, 32'h8000_0000, 32'hffff_ffff, 1'b1,
      '{oaht_pkg::ST_OK, 32'h0, 10'd1}},
    '{oaht_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1,
      '{oaht_pkg::ST_OK, 32'hffff_ffff, 10'd1}},
    // duplicate insert
    '{oaht_pkg::OP_INSERT, 32'h8000_0000, 32'h0000_0000, 1'b1,
      '{oaht_pkg::ST_EXISTS, 32'h0, 10'd1}},
    '{oaht_pkg::OP_INSERT, 32'h7fff_ffff, 32'h0000_0000, 1'b1,
      '{oaht_pkg::ST_OK, 32'h0, 10'd2}},
    '{oaht_pkg::OP_INSERT, 32'h0000_0000, 32'h1234_5678, 1'b1,
      '{oaht_pkg::ST_OK, 32'h0, 10'd3}},
    '{oaht_pkg::OP_INSERT, 32'hffff_ffff, 32'ha5a5_a5a5, 1'b1,
      '{oaht_pkg::ST_OK, 32'h0, 10'd4}},
    // remove leaves a tombstone in slot 0
    '{oaht_pkg::OP_REMOVE, 32'h8000_0000, 32'h0000_0000, 1'b1,
      '{oaht_pkg::ST_OK, 32'h0, 10'd3}},
    '{oaht_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1,
      '{oaht_pkg::ST_NOT_FOUND, 32'h0, 10'd3}},
    // probe walks past the tombstone
    '{oaht_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, PREDICTED},
    // insert reuses the tombstone
    '{oaht_pkg::OP_INSERT, 32'h0000_0008, 32'h5a5a_5a5a, 1'b0, PREDICTED},
    '{oaht_pkg::OP_INSERT, 32'h0000_0010, 32'h0000_0010, 1'b0, PREDICTED},
    '{oaht_pkg::OP_INSERT, 32'h0000_0018, 32'h0000_0018, 1'b0, PREDICTED},
    // load limit of 6 reached
    '{oaht_pkg::OP_INSERT, 32'h0000_0020, 32'h0000_0020, 1'b1,
      '{oaht_pkg::ST_FULL, 32'h0, 10'd6}},
    // full wins over already present
    '{oaht_pkg::OP_INSERT, 32'h0000_0008, 32'h0000_0000, 1'b1,
      '{oaht_pkg::ST_FULL, 32'h0, 10'd6}},
    '{oaht_pkg::OP_REMOVE, 32'h0000_0010, 32'h0000_0000, 1'b0, PREDICTED},
    // tombstones count toward the limit
    '{oaht_pkg::OP_INSERT, 32'h0000_0010, 32'h0000_0000, 1'b1,
      '{oaht_pkg::ST_FULL, 32'h0, 10'd5}},
    '{oaht_pkg::OP_GET, 32'h0000_0018, 32'h0000_0000, 1'b0, PREDICTED},
    '{oaht_pkg::OP_REMOVE, 32'hffff_ffff, 32'h0000_0000, 1'b0, PREDICTED},
    '{oaht_pkg::OP_GET, 32'hffff_ffff, 32'h0000_0000, 1'b0, PREDICTED},
    // unused op on a present key changes nothing
    '{OP_UNUSED, 32'h0000_0018, 32'h0000_0000, 1'b0, PREDICTED},
    '{oaht_pkg::OP_GET, 32'h0000_0008, 32'h0000_0000, 1'b0, PREDICTED}
  };

  // random phases: capacity written (out of range values included) and length
  localparam int unsigned PHASE_N = 8;
  localparam oaht_pkg::cfg_t PHASE_CFG [PHASE_N] =
    '{4'd0, 4'd15, 4'd4, 4'd12, 4'd5, 4'd7, 4'd3, 4'd6};
  localparam int unsigned PHASE_ITEMS [PHASE_N] = '{40, 40, 70, 30, 80, 60, 30, 60};
  localparam int unsigned CALM_PHASE = 2;
  localparam int unsigned POOL_N = 12;

  // clock and reset
  logic clk;
  logic rst_n = 1'b0;

  // block inputs, known from time zero
  logic cfg_wr_en = 1'b0;
  oaht_pkg::cfg_t cfg_wr_data = '0;
  logic in_valid = 1'b0;
  oaht_pkg::op_t in_op = oaht_pkg::OP_GET;
  logic signed [31:0] in_key = '0;
  logic [31:0] in_value = '0;
  logic out_stall = 1'b0;

  // block outputs
  logic in_stall;
  logic out_valid;
  oaht_pkg::status_t out_status;
  logic [31:0] out_value_out;
  logic [oaht_pkg::ENTRY_COUNT_W-1:0] out_entry_count;

  // predicted table contents
  logic [31:0] tab_key [SLOT_COUNT];
  logic [31:0] tab_val [SLOT_COUNT];
  oaht_pkg::mark_t tab_mark [SLOT_COUNT];
  int unsigned live_n;
  int unsigned tomb_n;
  oaht_pkg::cfg_t cap_reg;

  // answers still owed by the block, oldest first
  result_t answer_q [$];
  int unsigned sent_count = 0;
  int unsigned done_count = 0;
  int unsigned err_count = 0;
  bit calm = 1'b0;
  int unsigned cycle_count;

  open_address_hash_table_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_value_out   (out_value_out),
    .out_entry_count (out_entry_count)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // slots in use for the current capacity register, clamped to 3..10
  function automatic int unsigned slots_in_use();
    oaht_pkg::cfg_t lg;
    lg = cap_reg;
    if (lg < oaht_pkg::CAP_LOG2_MIN) lg = oaht_pkg::CAP_LOG2_MIN;
    if (lg > oaht_pkg::CAP_LOG2_MAX) lg = oaht_pkg::CAP_LOG2_MAX;
    return 32'd1 << lg;
  endfunction

  // empty every slot and zero both counters
  task automatic clear_table();
    int unsigned i;
    for (i = 0; i < SLOT_COUNT; i++) begin
      tab_mark[i] = oaht_pkg::MARK_EMPTY;
      tab_key[i] = '0;
      tab_val[i] = '0;
    end
    live_n = 0;
    tomb_n = 0;
  endtask

  // apply one operation to the predicted table and work out its answer
  task automatic apply_table_op(input oaht_pkg::op_t op, input logic [31:0] key,
                                input logic [31:0] value, output result_t res);
    int unsigned cap;
    int unsigned idx;
    int unsigned n;
    int unsigned tomb_idx;
    int unsigned target;
    logic [31:0] h;
    bit stop;
    bit have_tomb;
    bit have_target;
    cap = slots_in_use();
    h = key * oaht_pkg::HASH_MULT;
    idx = h & (cap - 1);
    res = '0;
    res.status = oaht_pkg::ST_NOT_FOUND;
    stop = 1'b0;
    have_tomb = 1'b0;
    have_target = 1'b0;
    tomb_idx = 0;
    target = 0;
    n = 0;
    case (op)
      oaht_pkg::OP_GET, oaht_pkg::OP_REMOVE: begin
        while (!stop && n < cap) begin
          if (tab_mark[idx] == oaht_pkg::MARK_EMPTY) begin
            stop = 1'b1;
          end else if (tab_mark[idx] == oaht_pkg::MARK_OCCUPIED &&
                       tab_key[idx] == key) begin
            stop = 1'b1;
            res.status = oaht_pkg::ST_OK;
            if (op == oaht_pkg::OP_GET) begin
              res.value_out = tab_val[idx];
            end else begin
              tab_mark[idx] = oaht_pkg::MARK_DELETED;
              tab_val[idx] = '0;
              if (live_n > 0) live_n--;
              tomb_n++;
            end
          end else begin
            idx = (idx + 1) & (cap - 1);
          end
          n++;
        end
      end
      oaht_pkg::OP_INSERT: begin
        if (live_n + tomb_n >= ((cap * oaht_pkg::LOAD_NUM) >> oaht_pkg::LOAD_SHIFT)) begin
          res.status = oaht_pkg::ST_FULL;
        end else begin
          res.status = oaht_pkg::ST_OK;
          while (!stop && n < cap) begin
            if (tab_mark[idx] == oaht_pkg::MARK_EMPTY) begin
              target = idx;
              have_target = 1'b1;
              stop = 1'b1;
            end else if (tab_mark[idx] == oaht_pkg::MARK_OCCUPIED &&
                         tab_key[idx] == key) begin
              res.status = oaht_pkg::ST_EXISTS;
              stop = 1'b1;
            end else begin
              if (tab_mark[idx] == oaht_pkg::MARK_DELETED && !have_tomb) begin
                tomb_idx = idx;
                have_tomb = 1'b1;
              end
              idx = (idx + 1) & (cap - 1);
            end
            n++;
          end
          if (res.status == oaht_pkg::ST_OK) begin
            if (have_tomb) begin
              target = tomb_idx;
              have_target = 1'b1;
              if (tomb_n > 0) tomb_n--;
            end
            if (have_target) begin
              tab_key[target] = key;
              tab_val[target] = value;
              tab_mark[target] = oaht_pkg::MARK_OCCUPIED;
              live_n++;
            end else begin
              res.status = oaht_pkg::ST_FULL;
            end
          end
        end
      end
      default: ;
    endcase
    res.entry_count = live_n[oaht_pkg::ENTRY_COUNT_W-1:0];
  endtask

  // present one request, hold it until accepted, then log what it must return
  task automatic send_request(input oaht_pkg::op_t op, input logic [31:0] key,
                              input logic [31:0] value, input bit typed,
                              input result_t want);
    result_t got;
    // random gap before the request
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_key <= key;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge
    apply_table_op(op, key, value, got);
    answer_q.push_back(typed ? want : got);
    sent_count++;
  endtask

  // write the capacity register once the block has gone quiet
  task automatic write_capacity(input oaht_pkg::cfg_t lg);
    in_valid <= 1'b0;
    @(posedge clk);
    while (done_count != sent_count) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= lg;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_reg = lg;
    clear_table();
  endtask

  // random traffic over a small pool of keys, half of them on one probe chain
  task automatic run_random_phase(input int unsigned items);
    logic [31:0] pool [POOL_N];
    logic [31:0] base;
    logic [31:0] key;
    int unsigned cap;
    int unsigned i;
    int unsigned roll;
    oaht_pkg::op_t op;
    cap = slots_in_use();
    base = $urandom;
    for (i = 0; i < POOL_N; i++) begin
      pool[i] = (i < POOL_N / 2) ? base + i * cap : $urandom;
    end
    for (i = 0; i < items; i++) begin
      roll = $urandom_range(99);
      if (roll < 40) op = oaht_pkg::OP_INSERT;
      else if (roll < 70) op = oaht_pkg::OP_GET;
      else if (roll < 95) op = oaht_pkg::OP_REMOVE;
      else op = OP_UNUSED;
      // mostly pool keys so gets and removes land, some raw noise
      if ($urandom_range(99) < 80) key = pool[$urandom_range(POOL_N - 1)];
      else key = $urandom;
      send_request(op, key, $urandom, 1'b0, PREDICTED);
    end
  endtask

  // result side: compare each accepted result, then pick the next stall
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d value=%h count=%0d",
                 $time, out_status, out_value_out, out_entry_count);
        err_count++;
      end else begin
        want = answer_q.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          err_count++;
        end
        if (out_value_out !== want.value_out) begin
          $display("%0t: value_out expected %h actual %h",
                   $time, want.value_out, out_value_out);
          err_count++;
        end
        if (out_entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d",
                   $time, want.entry_count, out_entry_count);
          err_count++;
        end
        done_count <= done_count + 1;
      end
    end
    out_stall <= !calm && ($urandom_range(99) < 26);
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int unsigned i;
    int unsigned p;
    cap_reg = oaht_pkg::CAP_LOG2_RESET;
    clear_table();
    // hold reset, then release it; the clearing pass shows up as in_stall
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows at the reset capacity
    for (i = 0; i < DIR_ROW_N; i++) begin
      send_request(DIR_ROWS[i].op, DIR_ROWS[i].key, DIR_ROWS[i].value,
                   DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    // random phases, each behind a capacity write
    for (p = 0; p < PHASE_N; p++) begin
      write_capacity(PHASE_CFG[p]);
      calm = (p == CALM_PHASE);
      run_random_phase(PHASE_ITEMS[p]);
    end
    calm = 1'b0;

    // drain, then wait for stray results
    in_valid <= 1'b0;
    @(posedge clk);
    while (done_count != sent_count) @(posedge clk);
    repeat (16) @(posedge clk);
    @(negedge clk);
    if (err_count == 0 && answer_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/oaht_pkg.sv
src/open_address_hash_table_core.sv
src/oaht_checker.sv
tb/tb.sv
